// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("event queue check failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("event queue check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/toeq_pkg.sv
// ----------------------------------------------------------------------------
// toeq_pkg
// Widths, codes and controller/datapath command types of the event queue.
// ----------------------------------------------------------------------------
package toeq_pkg;

   localparam int TIME_W        = 32;
   localparam int HANDLE_W      = 16;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 5;
   localparam int DEPTH_DEFAULT = 16;

   // Request action codes.
   typedef enum logic {
      ACTION_ENQUEUE = 1'b0,
      ACTION_DEQUEUE = 1'b1
   } action_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Datapath operations issued by the controller.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_POP,
      OP_REJECT
   } op_type;

   // Command bundle from controller to datapath.
   typedef struct packed {
      op_type     op;
      status_type code;
      logic       load_rsp;
   } cmd_type;

   // Status bundle from datapath to controller.
   typedef struct packed {
      logic full;
      logic empty;
   } sts_type;

endpackage

// File: hw/rtl/toeq_if.sv
// ----------------------------------------------------------------------------
// toeq_if
// Valid/ready channels for event queue requests and responses.
// ----------------------------------------------------------------------------
interface toeq_req_if;
   import toeq_pkg::*;

   logic                valid;
   logic                ready;
   logic                action;
   logic [TIME_W-1:0]   event_time;
   logic [HANDLE_W-1:0] event_handle;

   modport source (output valid, action, event_time, event_handle, input ready);
   modport sink   (input valid, action, event_time, event_handle, output ready);
endinterface

interface toeq_rsp_if;
   import toeq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TIME_W-1:0]   removed_time;
   logic [HANDLE_W-1:0] removed_handle;
   logic                head_valid;
   logic [TIME_W-1:0]   head_time;
   logic [HANDLE_W-1:0] head_handle;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, status, removed_time, removed_handle, head_valid,
                   head_time, head_handle, entry_count, input ready);
   modport sink   (input valid, status, removed_time, removed_handle, head_valid,
                   head_time, head_handle, entry_count, output ready);
endinterface

// File: hw/rtl/toeq_ctrl.sv
// ----------------------------------------------------------------------------
// toeq_ctrl
// Controller: takes one request, issues the queue operation, then loads the
// response register as soon as it is free.
// ----------------------------------------------------------------------------
module toeq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_action,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  toeq_pkg::sts_type sts,
   output toeq_pkg::cmd_type cmd
);
   import toeq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   // A request is taken only while idle and out of reset.
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Decode the request into a queue operation, refusing illegal ones.
   always_comb begin
      cmd.op       = OP_NONE;
      cmd.code     = STATUS_OK;
      cmd.load_rsp = (state_ff == S_REPORT) && rsp_free;
      if (accept) begin
         unique case (req_action)
            ACTION_ENQUEUE: begin
               if (sts.full) begin
                  cmd.op   = OP_REJECT;
                  cmd.code = STATUS_FULL;
               end else begin
                  cmd.op = OP_PUSH;
               end
            end
            ACTION_DEQUEUE: begin
               if (sts.empty) begin
                  cmd.op   = OP_REJECT;
                  cmd.code = STATUS_EMPTY;
               end else begin
                  cmd.op = OP_POP;
               end
            end
            default: cmd.op = OP_NONE;
         endcase
      end
   end

   // Next state and response-valid flag.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_REPORT;
            end
         end
         S_REPORT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/toeq_dpath.sv
// ----------------------------------------------------------------------------
// toeq_dpath
// Datapath: a sorted shift-register array of slots with one comparator per
// slot, the entry count and the response register.
// ----------------------------------------------------------------------------
module toeq_dpath #(
   parameter int DEPTH = toeq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  toeq_pkg::cmd_type             cmd,
   input  logic [toeq_pkg::TIME_W-1:0]   req_time,
   input  logic [toeq_pkg::HANDLE_W-1:0] req_handle,
   output toeq_pkg::sts_type             sts,
   output logic [toeq_pkg::STATUS_W-1:0] rsp_status,
   output logic [toeq_pkg::TIME_W-1:0]   rsp_removed_time,
   output logic [toeq_pkg::HANDLE_W-1:0] rsp_removed_handle,
   output logic                          rsp_head_valid,
   output logic [toeq_pkg::TIME_W-1:0]   rsp_head_time,
   output logic [toeq_pkg::HANDLE_W-1:0] rsp_head_handle,
   output logic [toeq_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import toeq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [TIME_W-1:0]   slot_time_ff   [DEPTH];
   logic [TIME_W-1:0]   slot_time_in   [DEPTH];
   logic [HANDLE_W-1:0] slot_handle_ff [DEPTH];
   logic [HANDLE_W-1:0] slot_handle_in [DEPTH];
   logic [CW-1:0]       count_ff, count_in;
   logic [DEPTH-1:0]    keep;

   status_type          code_ff;
   logic [TIME_W-1:0]   rem_time_ff;
   logic [HANDLE_W-1:0] rem_handle_ff;

   status_type          rsp_status_ff;
   logic [TIME_W-1:0]   rsp_removed_time_ff;
   logic [HANDLE_W-1:0] rsp_removed_handle_ff;
   logic                rsp_head_valid_ff;
   logic [TIME_W-1:0]   rsp_head_time_ff;
   logic [HANDLE_W-1:0] rsp_head_handle_ff;
   logic [COUNT_W-1:0]  rsp_entry_count_ff;
   logic [CW+COUNT_W-1:0] count_wide;

   assign sts.full  = (count_ff == CW'(DEPTH));
   assign sts.empty = (count_ff == '0);

   // Each occupied slot whose time is not later than the new one stays put.
   // The queue is sorted, so these flags form a prefix.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         keep[i] = (CW'(i) < count_ff) && (slot_time_ff[i] <= req_time);
      end
   end

   // Slot update: insert with shift toward the tail, or shift toward the head.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_time_in[i]   = slot_time_ff[i];
         slot_handle_in[i] = slot_handle_ff[i];
      end
      count_in = count_ff;
      case (cmd.op)
         OP_PUSH: begin
            if (!keep[0]) begin
               slot_time_in[0]   = req_time;
               slot_handle_in[0] = req_handle;
            end
            for (int i = 1; i < DEPTH; i++) begin
               if (!keep[i]) begin
                  if (keep[i-1]) begin
                     slot_time_in[i]   = req_time;
                     slot_handle_in[i] = req_handle;
                  end else begin
                     slot_time_in[i]   = slot_time_ff[i-1];
                     slot_handle_in[i] = slot_handle_ff[i-1];
                  end
               end
            end
            count_in = count_ff + 1'b1;
         end
         OP_POP: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               slot_time_in[i]   = slot_time_ff[i+1];
               slot_handle_in[i] = slot_handle_ff[i+1];
            end
            count_in = count_ff - 1'b1;
         end
         default: count_in = count_ff;
      endcase
   end

   // Slot array and count.
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_time_ff[i]   <= slot_time_in[i];
         slot_handle_ff[i] <= slot_handle_in[i];
      end
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Status and removed entry of the operation just performed.
   always_ff @(posedge clock) begin
      if (cmd.op != OP_NONE) begin
         code_ff <= cmd.code;
         if (cmd.op == OP_POP) begin
            rem_time_ff   <= slot_time_ff[0];
            rem_handle_ff <= slot_handle_ff[0];
         end else begin
            rem_time_ff   <= '0;
            rem_handle_ff <= '0;
         end
      end
   end

   // The reported count keeps its low bits only.
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   // Response register, loaded once the queue holds the post-operation state.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff         <= code_ff;
         rsp_removed_time_ff   <= rem_time_ff;
         rsp_removed_handle_ff <= rem_handle_ff;
         rsp_head_valid_ff     <= !sts.empty;
         rsp_head_time_ff      <= sts.empty ? '0 : slot_time_ff[0];
         rsp_head_handle_ff    <= sts.empty ? '0 : slot_handle_ff[0];
         rsp_entry_count_ff    <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_time   = rsp_removed_time_ff;
   assign rsp_removed_handle = rsp_removed_handle_ff;
   assign rsp_head_valid     = rsp_head_valid_ff;
   assign rsp_head_time      = rsp_head_time_ff;
   assign rsp_head_handle    = rsp_head_handle_ff;
   assign rsp_entry_count    = rsp_entry_count_ff;

endmodule

// File: hw/rtl/time_ordered_event_queue_top.sv
// The request transfer moves the controller to S_REPORT; from there it loads the
// response register and raises the response valid once the register is free.
// The controller takes a request in S_IDLE and loads the response register in
// S_REPORT before it takes another, so it takes no new request until the last
// one's response is loaded. A response waiting to be taken does not stop the
// next request transfer; the one after that waits until the response transfers.
// Reset (synchronous, active high) empties the queue and drops any response;
// slot contents are left as they are.
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// time_ordered_event_queue_top
// Bounded event queue kept in ascending time order, ties in arrival order.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_top #(
   parameter int DEPTH = toeq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   toeq_req_if.sink    req,
   toeq_rsp_if.source  rsp
);
   import toeq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Controller.
   toeq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_action (req.action),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath.
   toeq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_time           (req.event_time),
      .req_handle         (req.event_handle),
      .sts                (sts),
      .rsp_status         (rsp.status),
      .rsp_removed_time   (rsp.removed_time),
      .rsp_removed_handle (rsp.removed_handle),
      .rsp_head_valid     (rsp.head_valid),
      .rsp_head_time      (rsp.head_time),
      .rsp_head_handle    (rsp.head_handle),
      .rsp_entry_count    (rsp.entry_count)
   );

   // Checks on controller and datapath cooperation.
   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, req.valid && req.ready, !req.ready)
   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, cmd.op == OP_PUSH, !sts.full)
   `ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, cmd.op == OP_POP, !sts.empty)
   `ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_rsp, rsp.valid)

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Exercises the time-ordered event queue through its request and response
// channels. Requests come from a queue that an initial block fills: a short
// directed sequence that reaches empty, full and equal times, and then bursts
// of random enqueues and dequeues. A behavioral copy of the sorted queue
// predicts each response, and the monitor checks every field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import toeq_pkg::*;

   localparam int CLK_PERIOD      = 8;
   localparam int RESET_CYCLES    = 6;
   localparam int QUEUE_DEPTH     = DEPTH_DEFAULT;
   localparam int ITEMS_PER_PHASE = 276;
   localparam int HOLD_CYCLES     = 150;
   localparam int DRAIN_CYCLES    = 10;
   localparam int CYCLE_LIMIT     = 200000;

   typedef struct {
      action_type          act;
      logic [TIME_W-1:0]   stamp;
      logic [HANDLE_W-1:0] id;
   } stim_request_type;

   typedef struct {
      logic [TIME_W-1:0]   stamp;
      logic [HANDLE_W-1:0] id;
   } event_entry_type;

   typedef struct {
      status_type          status;
      logic [TIME_W-1:0]   removed_time;
      logic [HANDLE_W-1:0] removed_handle;
      logic                head_valid;
      logic [TIME_W-1:0]   head_time;
      logic [HANDLE_W-1:0] head_handle;
      logic [COUNT_W-1:0]  entry_count;
   } queue_outcome_type;

   logic clock = 1'b0;
   logic reset;

   toeq_req_if req_ch ();
   toeq_rsp_if rsp_ch ();

   time_ordered_event_queue_top #(
      .DEPTH (QUEUE_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   stim_request_type  pending_requests[$];
   event_entry_type   model_events[$];
   queue_outcome_type expected_outcomes[$];

   int send_idle_pct;
   int take_idle_pct;
   int mismatch_count = 0;
   int checked_count  = 0;
   int enqueue_count  = 0;
   int dequeue_count  = 0;
   int tie_inserts    = 0;
   int empty_refusals = 0;
   int full_refusals  = 0;
   int cycle_count    = 0;

   logic stall_trigger = 1'b0;
   logic stall_seen    = 1'b0;
   int   hold_left     = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Applies one request to the sorted model and returns the response it must produce.
   function automatic queue_outcome_type step_event_order(action_type act,
                                                          logic [TIME_W-1:0] stamp,
                                                          logic [HANDLE_W-1:0] id);
      queue_outcome_type outcome;
      event_entry_type   entry;
      int                pos;
      outcome.status         = STATUS_OK;
      outcome.removed_time   = '0;
      outcome.removed_handle = '0;
      if (act == ACTION_ENQUEUE) begin
         if (model_events.size() >= QUEUE_DEPTH) begin
            outcome.status = STATUS_FULL;
            full_refusals++;
         end else begin
            // The new event goes behind every stored event with a time not later than its own.
            pos = 0;
            while (pos < model_events.size() && model_events[pos].stamp <= stamp) begin
               pos++;
            end
            if (pos > 0 && model_events[pos - 1].stamp == stamp) begin
               tie_inserts++;
            end
            entry.stamp = stamp;
            entry.id    = id;
            model_events.insert(pos, entry);
            enqueue_count++;
         end
      end else if (model_events.size() == 0) begin
         outcome.status = STATUS_EMPTY;
         empty_refusals++;
      end else begin
         entry                  = model_events.pop_front();
         outcome.removed_time   = entry.stamp;
         outcome.removed_handle = entry.id;
         dequeue_count++;
      end
      outcome.head_valid  = model_events.size() != 0;
      outcome.head_time   = '0;
      outcome.head_handle = '0;
      if (outcome.head_valid) begin
         outcome.head_time   = model_events[0].stamp;
         outcome.head_handle = model_events[0].id;
      end
      outcome.entry_count = COUNT_W'(model_events.size());
      return outcome;
   endfunction

   function automatic void check_field(string field, logic [TIME_W-1:0] want,
                                       logic [TIME_W-1:0] got);
      if (got !== want) begin
         $error("%s expected 0x%0h got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic add_request(action_type act, logic [TIME_W-1:0] stamp,
                              logic [HANDLE_W-1:0] id);
      stim_request_type item;
      item.act   = act;
      item.stamp = stamp;
      item.id    = id;
      pending_requests.push_back(item);
   endtask

   // Random traffic in bursts: fill runs, drain runs and mixed runs, so the queue
   // swings between empty and full. Small times make equal keys common.
   task automatic add_random_requests(int total);
      int                added;
      int                burst;
      int                mode;
      int                enq_pct;
      logic [TIME_W-1:0] stamp;
      added = 0;
      while (added < total) begin
         mode  = $urandom_range(9);
         burst = $urandom_range(20, 4);
         if (mode < 3) begin
            enq_pct = 100;
         end else if (mode < 6) begin
            enq_pct = 0;
         end else begin
            enq_pct = 55;
         end
         for (int k = 0; k < burst && added < total; k++) begin
            case ($urandom_range(9))
               0:       stamp = '0;
               1:       stamp = '1;
               2, 3, 4: stamp = $urandom_range(15);
               default: stamp = $urandom;
            endcase
            add_request(($urandom_range(99) < enq_pct) ? ACTION_ENQUEUE : ACTION_DEQUEUE,
                        stamp, HANDLE_W'($urandom));
            added++;
         end
      end
   endtask

   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_ch.valid || expected_outcomes.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Request driver: predicts each transfer and offers the next pending request.
   always @(posedge clock) begin
      stim_request_type next_req;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_outcomes.push_back(step_event_order(action_type'(req_ch.action),
                                                         req_ch.event_time,
                                                         req_ch.event_handle));
         end
         // A request that has not transferred yet stays on the bus unchanged.
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.action       <= next_req.act;
               req_ch.event_time   <= next_req.stamp;
               req_ch.event_handle <= next_req.id;
            end else begin
               req_ch.valid        <= 1'b0;
               req_ch.action       <= 1'($urandom);
               req_ch.event_time   <= $urandom;
               req_ch.event_handle <= HANDLE_W'($urandom);
            end
         end
      end
   end

   // Long receiver hold-off, started by toggling stall_trigger.
   always @(posedge clock) begin
      if (stall_trigger != stall_seen) begin
         stall_seen <= stall_trigger;
         hold_left  <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: checks each transfer against the oldest prediction.
   always @(posedge clock) begin
      queue_outcome_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("status", TIME_W'(want.status), TIME_W'(rsp_ch.status));
               check_field("removed_time", want.removed_time, rsp_ch.removed_time);
               check_field("removed_handle", TIME_W'(want.removed_handle),
                           TIME_W'(rsp_ch.removed_handle));
               check_field("head_valid", TIME_W'(want.head_valid),
                           TIME_W'(rsp_ch.head_valid));
               check_field("head_time", want.head_time, rsp_ch.head_time);
               check_field("head_handle", TIME_W'(want.head_handle),
                           TIME_W'(rsp_ch.head_handle));
               check_field("entry_count", TIME_W'(want.entry_count),
                           TIME_W'(rsp_ch.entry_count));
               checked_count++;
            end
         end
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("time_ordered_event_queue_top: mismatch");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = 1'b0;
      req_ch.event_time   = '0;
      req_ch.event_handle = '0;
      rsp_ch.ready        = 1'b0;
      send_idle_pct       = 28;
      take_idle_pct       = 82;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: dequeue while empty, extreme keys and handles, equal times,
      // fill to the limit, one enqueue on a full queue, then drain a few.
      add_request(ACTION_DEQUEUE, '1, '1);
      add_request(ACTION_ENQUEUE, '0, '0);
      add_request(ACTION_ENQUEUE, '1, '1);
      for (int k = 1; k <= 3; k++) begin
         add_request(ACTION_ENQUEUE, 32'h100, HANDLE_W'(k));
      end
      add_request(ACTION_ENQUEUE, '0, 16'h00AA);
      for (int k = 0; k < QUEUE_DEPTH - 6; k++) begin
         add_request(ACTION_ENQUEUE, $urandom_range(32'h200), HANDLE_W'($urandom));
      end
      add_request(ACTION_ENQUEUE, '0, 16'h5A5A);
      for (int k = 0; k < 4; k++) begin
         add_request(ACTION_DEQUEUE, $urandom, HANDLE_W'($urandom));
      end
      add_random_requests(ITEMS_PER_PHASE);
      wait_until_drained();

      send_idle_pct = 82;
      take_idle_pct = 28;
      add_random_requests(ITEMS_PER_PHASE);
      wait_until_drained();

      // No idling; the receiver first holds off so the queue backs up.
      send_idle_pct = 0;
      take_idle_pct = 0;
      stall_trigger = ~stall_trigger;
      add_random_requests(ITEMS_PER_PHASE);
      wait_until_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d enqueues (%0d onto an equal time) and %0d dequeues, %0d checked.",
               enqueue_count, tie_inserts, dequeue_count, checked_count);
      $display("Refused %0d dequeues on an empty queue and %0d enqueues on a full queue.",
               empty_refusals, full_refusals);
      if (mismatch_count == 0) begin
         $display("time_ordered_event_queue_top: match");
      end else begin
         $display("time_ordered_event_queue_top: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/toeq_pkg.sv
hw/rtl/toeq_if.sv
hw/rtl/toeq_ctrl.sv
hw/rtl/toeq_dpath.sv
hw/rtl/time_ordered_event_queue_top.sv
tb/sv/tb_top.sv
